[rtl/core/pce_pkg.sv]
// shared types, constants and sequencer states for the pearson correlation engine
// no dependencies
package pce_pkg;

  localparam int unsigned MAX_PAIRS_DEF   = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CALC_W          = 64;
  localparam int unsigned Q_ONE           = 16384;
  localparam int unsigned Q_SHIFT         = 14;
  localparam int unsigned MEAN_SHIFT      = 8;

  typedef struct packed {
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic               last;
  } pce_in_t;

  typedef struct packed {
    logic signed [49:0] covariance;
    logic        [48:0] variance_x;
    logic        [48:0] variance_y;
    logic signed [15:0] correlation;
    logic               degenerate;
    logic               overflowed;
    logic        [10:0] pair_count;
  } pce_out_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MX,
    S_MY,
    S_PASS,
    S_CV,
    S_VX,
    S_VY,
    S_SQX,
    S_SQY,
    S_MUL,
    S_Q,
    S_DONE
  } pce_state_t;

endpackage

[rtl/core/pearson_correlation_engine_top.sv]
// Pairs load at one transfer per cycle whenever in_stall is low into two sample memories while
// running sums build up. The transfer marked last starts the computation: two divides for the
// means, a pass over the memories, three divides by n, two square roots, a multiply step, a
// final divide (skipped when a variance is zero) and a step to load the result, during all of
// which in_stall is high. The single result waits in an output register; loading of the next
// vectors goes on while it is unread. Pairs beyond MAX_PAIRS are dropped and flagged.
// depends on pce_pkg, pce_div, pce_isqrt
module pearson_correlation_engine_top #(
  parameter int unsigned MAX_PAIRS   = pce_pkg::MAX_PAIRS_DEF,
  parameter int unsigned SAMPLE_BITS = pce_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pce_pkg::pce_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pce_pkg::pce_out_t out_data
);
  import pce_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PAIRS + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned D_W    = SAMPLE_BITS + MEAN_SHIFT + 2;
  localparam int unsigned P_W    = 2 * D_W;

  pce_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] x_mem [MAX_PAIRS];
  logic [SAMPLE_BITS-1:0] y_mem [MAX_PAIRS];

  logic                     in_acc, has_room, rd_en, emit;
  logic                     div_start, sq_start, div_done, sq_done, busy_r;
  logic [CNT_W-1:0]         cnt_r, rd_cnt_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic                     ovf_r;
  logic                     v1_r, v2_r, v3_r;
  logic [CALC_W-1:0]        xraw, yraw;
  logic signed [SAMPLE_BITS-1:0] xs, ys, x_q_r, y_q_r;
  logic signed [D_W-1:0]    dx_r, dy_r;
  logic signed [P_W-1:0]    pc_r, px_r, py_r;
  logic signed [CALC_W-1:0] mx_r, my_r, cov_r, sval, sres;
  logic [CALC_W-1:0]        acc_c_r, acc_x_r, acc_y_r, vx_r, vy_r, denom_r, den_w;
  logic [CALC_W-1:0]        cov_mag, div_dvd, div_dvs, div_quo, sq_in;
  logic [CALC_W/2-1:0]      sx_r, sy_r, sq_root;
  logic [Q_SHIFT:0]         q_r, q_use;
  logic                     div_neg, degen, out_valid_r;
  pce_out_t                 out_data_r;

  assign xraw     = CALC_W'($unsigned(in_data.x_sample));
  assign yraw     = CALC_W'($unsigned(in_data.y_sample));
  assign xs       = xraw[SAMPLE_BITS-1:0];
  assign ys       = yraw[SAMPLE_BITS-1:0];
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign has_room = (cnt_r < CNT_W'(MAX_PAIRS));
  assign rd_en    = (state_r == S_PASS) && (rd_cnt_r < cnt_r);
  assign degen    = (vx_r == '0) || (vy_r == '0);
  assign cov_mag  = cov_r[CALC_W-1] ? CALC_W'(-cov_r) : CALC_W'(cov_r);
  assign den_w    = CALC_W'(sx_r) * CALC_W'(sy_r);
  assign sq_in    = (state_r == S_SQX) ? vx_r : vy_r;

  // divider operand select
  always_comb begin
    sval    = '0;
    div_dvs = CALC_W'(cnt_r);
    case (state_r)
      S_MX:    sval = CALC_W'(sum_x_r) <<< MEAN_SHIFT;
      S_MY:    sval = CALC_W'(sum_y_r) <<< MEAN_SHIFT;
      S_CV:    sval = acc_c_r;
      S_VX:    sval = acc_x_r;
      S_VY:    sval = acc_y_r;
      default: sval = '0;
    endcase
    if (state_r == S_Q) begin
      div_neg = 1'b0;
      div_dvd = {cov_mag[CALC_W-Q_SHIFT-1:0], {Q_SHIFT{1'b0}}};
      div_dvs = denom_r;
    end else begin
      div_neg = sval[CALC_W-1];
      div_dvd = div_neg ? CALC_W'(-sval) : CALC_W'(sval);
    end
    sres = div_neg ? -$signed(div_quo) : $signed(div_quo);
  end

  pce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  pce_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    sq_start  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_data.last) state_nxt = S_MX;
      end
      S_MX, S_MY, S_CV, S_VX, S_VY, S_Q: begin
        div_start = !busy_r;
        if (div_done) begin
          case (state_r)
            S_MX:    state_nxt = S_MY;
            S_MY:    state_nxt = S_PASS;
            S_CV:    state_nxt = S_VX;
            S_VX:    state_nxt = S_VY;
            S_VY:    state_nxt = S_SQX;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PASS: begin
        if (rd_cnt_r == cnt_r && !v1_r && !v2_r && !v3_r) state_nxt = S_CV;
      end
      S_SQX, S_SQY: begin
        sq_start = !busy_r;
        if (sq_done) state_nxt = (state_r == S_SQX) ? S_SQY : S_MUL;
      end
      S_MUL: begin
        state_nxt = degen ? S_DONE : S_Q;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          emit      = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (has_room) begin
          cnt_r   <= cnt_r + 1'b1;
          sum_x_r <= sum_x_r + SUM_W'(xs);
          sum_y_r <= sum_y_r + SUM_W'(ys);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (div_start || sq_start) begin
        busy_r <= 1'b1;
      end else if (div_done || sq_done) begin
        busy_r <= 1'b0;
      end
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (rd_en) rd_cnt_r <= rd_cnt_r + 1'b1;
      if (state_r == S_MY && div_done) rd_cnt_r <= '0;
      if (emit) begin
        cnt_r       <= '0;
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // sample memories
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      x_mem[cnt_r[ADDR_W-1:0]] <= xs;
      y_mem[cnt_r[ADDR_W-1:0]] <= ys;
    end
    if (rd_en) begin
      x_q_r <= x_mem[rd_cnt_r[ADDR_W-1:0]];
      y_q_r <= y_mem[rd_cnt_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      dx_r <= D_W'((CALC_W'(x_q_r) <<< MEAN_SHIFT) - mx_r);
      dy_r <= D_W'((CALC_W'(y_q_r) <<< MEAN_SHIFT) - my_r);
    end
    if (v2_r) begin
      pc_r <= dx_r * dy_r;
      px_r <= dx_r * dx_r;
      py_r <= dy_r * dy_r;
    end
    if (v3_r) begin
      acc_c_r <= acc_c_r + CALC_W'(pc_r);
      acc_x_r <= acc_x_r + CALC_W'(px_r);
      acc_y_r <= acc_y_r + CALC_W'(py_r);
    end
    if (div_done) begin
      case (state_r)
        S_MX: mx_r <= sres;
        S_MY: begin
          my_r    <= sres;
          acc_c_r <= '0;
          acc_x_r <= '0;
          acc_y_r <= '0;
        end
        S_CV: cov_r <= sres;
        S_VX: vx_r <= sres[CALC_W-1] ? '0 : CALC_W'(sres);
        S_VY: vy_r <= sres[CALC_W-1] ? '0 : CALC_W'(sres);
        S_Q: begin
          if (denom_r == '0 || div_quo > CALC_W'(Q_ONE)) begin
            q_r <= (Q_SHIFT+1)'(Q_ONE);
          end else begin
            q_r <= div_quo[Q_SHIFT:0];
          end
        end
        default: ;
      endcase
    end
    if (sq_done) begin
      if (state_r == S_SQX) begin
        sx_r <= sq_root;
      end else begin
        sy_r <= sq_root;
      end
    end
    if (state_r == S_MUL) denom_r <= den_w;
    if (emit) begin
      out_data_r.covariance  <= cov_r[49:0];
      out_data_r.variance_x  <= vx_r[48:0];
      out_data_r.variance_y  <= vy_r[48:0];
      out_data_r.correlation <= cov_r[CALC_W-1] ? -$signed(16'(q_use)) : $signed(16'(q_use));
      out_data_r.degenerate  <= degen;
      out_data_r.overflowed  <= ovf_r;
      out_data_r.pair_count  <= 11'(cnt_r);
    end
  end

  assign q_use     = degen ? '0 : q_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall)
    else $error("input not stalled after last transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAIRS))
    else $error("stored count beyond capacity");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.correlation == 16'sd0))
    else $error("degenerate result with nonzero correlation");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.correlation <= 16'sd16384 && out_data.correlation >= -16'sd16384))
    else $error("correlation outside plus or minus one");

endmodule

[rtl/core/pce_div.sv]
// sequential unsigned divider, one quotient bit per cycle
// depends on pce_pkg
module pce_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pce_pkg::CALC_W-1:0] dividend,
  input  logic [pce_pkg::CALC_W-1:0] divisor,
  output logic                       done,
  output logic [pce_pkg::CALC_W-1:0] quotient
);
  import pce_pkg::*;

  localparam int unsigned CW = $clog2(CALC_W);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [CALC_W:0]   rem_r;
  logic [CALC_W-1:0] quo_r;
  logic [CALC_W-1:0] dvs_r;
  logic [CALC_W:0]   trial;

  assign trial = {rem_r[CALC_W-1:0], quo_r[CALC_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(CALC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= trial - {1'b0, dvs_r};
        quo_r <= {quo_r[CALC_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[CALC_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/pce_isqrt.sv]
// sequential integer square root, two radicand bits per cycle
// depends on pce_pkg
module pce_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pce_pkg::CALC_W-1:0]   value,
  output logic                         done,
  output logic [pce_pkg::CALC_W/2-1:0] root
);
  import pce_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CALC_W-1:0] v_r;
  logic [CALC_W-1:0] r_r;
  logic [CALC_W-1:0] bit_r;
  logic [CALC_W-1:0] sum;

  assign sum = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == CALC_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      r_r   <= '0;
      bit_r <= CALC_W'(1) << (CALC_W - 2);
    end else if (busy_r) begin
      if (v_r >= sum) begin
        v_r <= v_r - sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[CALC_W/2-1:0];

endmodule

[test/testbench.sv]
// self-checking testbench for pearson_correlation_engine_top: paired sample sets in, one
// correlation result out per set, predicted in-bench and compared field by field
// depends on pce_pkg and the pearson_correlation_engine_top rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pce_pkg::*;

  localparam int unsigned CAPACITY = MAX_PAIRS_DEF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pce_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pce_out_t out_data;

  pce_in_t  pending_pairs[$];
  pce_out_t expected_results[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       phase = 0;
  logic     hold_on = 1'b0;

  logic signed [15:0] x_mem[CAPACITY];
  logic signed [15:0] y_mem[CAPACITY];
  int       pair_cnt = 0;
  longint   x_sum = 0;
  longint   y_sum = 0;
  bit       dropped = 0;

  pearson_correlation_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic absorb_pair(pce_in_t p);
    longint n, mx, my, dx, dy, cov, vx, vy;
    longint acc_c, acc_x, acc_y;
    longint unsigned den, mag, q;
    bit neg, degen;
    pce_out_t r;
    if (pair_cnt < CAPACITY) begin
      x_mem[pair_cnt] = p.x_sample;
      y_mem[pair_cnt] = p.y_sample;
      pair_cnt++;
      x_sum += p.x_sample;
      y_sum += p.y_sample;
    end else begin
      dropped = 1;
    end
    if (!p.last) return;
    n = pair_cnt;
    mx = (x_sum * 256) / n;
    my = (y_sum * 256) / n;
    acc_c = 0;
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i < pair_cnt; i++) begin
      dx = longint'(x_mem[i]) * 256 - mx;
      dy = longint'(y_mem[i]) * 256 - my;
      acc_c += dx * dy;
      acc_x += dx * dx;
      acc_y += dy * dy;
    end
    cov = acc_c / n;
    vx = acc_x / n;
    vy = acc_y / n;
    if (vx < 0) vx = 0;
    if (vy < 0) vy = 0;
    degen = (vx == 0) || (vy == 0);
    neg = cov < 0;
    q = 0;
    if (!degen) begin
      den = root_floor(vx) * root_floor(vy);
      mag = neg ? -cov : cov;
      mag *= 16384;
      q = (den != 0) ? mag / den : 16384;
      if (q > 16384) q = 16384;
    end
    r.covariance = cov[49:0];
    r.variance_x = vx[48:0];
    r.variance_y = vy[48:0];
    r.correlation = neg ? 16'(-q) : 16'(q);
    r.degenerate = degen;
    r.overflowed = dropped;
    r.pair_count = pair_cnt[10:0];
    expected_results.push_back(r);
    pair_cnt = 0;
    x_sum = 0;
    y_sum = 0;
    dropped = 0;
  endtask

  task automatic flag(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_pair(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_pairs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    pce_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("unexpected transfer at %0t", $realtime);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.covariance !== e.covariance)
          flag("covariance", out_data.covariance, e.covariance);
        if (out_data.variance_x !== e.variance_x)
          flag("variance_x", out_data.variance_x, e.variance_x);
        if (out_data.variance_y !== e.variance_y)
          flag("variance_y", out_data.variance_y, e.variance_y);
        if (out_data.correlation !== e.correlation)
          flag("correlation", out_data.correlation, e.correlation);
        if (out_data.degenerate !== e.degenerate)
          flag("degenerate", out_data.degenerate, e.degenerate);
        if (out_data.overflowed !== e.overflowed)
          flag("overflowed", out_data.overflowed, e.overflowed);
        if (out_data.pair_count !== e.pair_count)
          flag("pair_count", out_data.pair_count, e.pair_count);
      end
    end
  end

  function automatic logic signed [15:0] pick(int span);
    if (span >= 16) return 16'($urandom);
    return 16'($urandom_range(2 * span, 0) - span);
  endfunction

  // kinds: 0 and 1 random, 2 constant x, 3 y equals x, 4 y opposite x, 5 noisy line
  task automatic queue_set(int len, int kind);
    pce_in_t p;
    logic signed [15:0] c;
    int span;
    span = ($urandom_range(3) == 0) ? 16 : $urandom_range(200, 1);
    c = pick(16);
    for (int i = 0; i < len; i++) begin
      p.x_sample = (kind == 2) ? c : pick(span);
      case (kind)
        3: p.y_sample = p.x_sample;
        4: p.y_sample = ~p.x_sample;
        5: p.y_sample = 16'(3 * p.x_sample / 4) + 16'($urandom_range(20) - 10);
        default: p.y_sample = pick(span);
      endcase
      p.last = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  task automatic queue_pair(logic signed [15:0] x, logic signed [15:0] y, logic l);
    pce_in_t p;
    p.x_sample = x;
    p.y_sample = y;
    p.last = l;
    pending_pairs.push_back(p);
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic queue_random(int quota);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 2) : $urandom_range(12, 1);
      queue_set(len, $urandom_range(5));
      cnt += len;
    end
  endtask

  // long output hold-off so the result register fills and the input backs up
  initial begin
    wait (phase == 3);
    repeat (200) @(posedge clk);
    hold_on <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("pearson_correlation_engine_top verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // single pair, extremes, saturation, constant vectors
    queue_pair(16'sh7fff, -16'sh8000, 1'b1);
    queue_pair(-16'sh8000, -16'sh8000, 1'b0);
    queue_pair(16'sh7fff, 16'sh7fff, 1'b1);
    queue_pair(-16'sh8000, 16'sh7fff, 1'b0);
    queue_pair(16'sh7fff, -16'sh8000, 1'b0);
    queue_pair(-16'sh8000, 16'sh7fff, 1'b1);
    queue_pair(16'sh0005, 16'sh0001, 1'b0);
    queue_pair(16'sh0005, -16'sh0003, 1'b0);
    queue_pair(16'sh0005, 16'sh0007, 1'b1);
    queue_set(4, 3);
    queue_set(4, 4);
    queue_set(5, 5);
    drain();
    // memory full, extra pairs dropped including the marked one
    queue_set(CAPACITY + 6, 0);
    drain();
    queue_random(200);
    drain();

    phase = 1;
    send_idle_pct = 88;
    stall_pct = 0;
    queue_random(240);
    drain();

    phase = 2;
    send_idle_pct = 0;
    stall_pct = 88;
    queue_random(240);
    drain();

    phase = 3;
    send_idle_pct = 34;
    stall_pct = 34;
    queue_random(240);
    drain();

    repeat (1500) @(posedge clk);
    errors += expected_results.size();
    if (errors == 0) begin
      $display("pearson_correlation_engine_top verification clean");
    end else begin
      $display("pearson_correlation_engine_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pce_pkg.sv
rtl/core/pce_div.sv
rtl/core/pce_isqrt.sv
rtl/core/pearson_correlation_engine_top.sv
test/testbench.sv
